[rtl/core/hfr_pkg.sv]
package hfr_pkg;

   // Header layout: sensor, type, length high, length low, two checksum bytes.
   localparam logic [15:0] HDR_IDX_SENSOR  = 16'd0;
   localparam logic [15:0] HDR_IDX_TYPE    = 16'd1;
   localparam logic [15:0] HDR_IDX_LEN_HI  = 16'd2;
   localparam logic [15:0] HDR_IDX_LEN_LO  = 16'd3;
   localparam logic [15:0] HDR_IDX_LAST    = 16'd5;

   // Reset value of the frame start character.
   localparam logic [7:0] SYNC_CHAR_RESET = 8'h7E;

   // Message type codes recognized by the classifier.
   localparam logic [7:0] TYPE_DATA_EVENT  = 8'h04;
   localparam logic [7:0] TYPE_SENSOR_INFO = 8'h09;
   localparam logic [7:0] TYPE_FW_VERSION  = 8'hCD;

   // Message kind codes on the result channel.
   localparam logic [1:0] KIND_DATA_EVENT  = 2'd0;
   localparam logic [1:0] KIND_SENSOR_INFO = 2'd1;
   localparam logic [1:0] KIND_FW_VERSION  = 2'd2;
   localparam logic [1:0] KIND_OTHER       = 2'd3;

   // Depth of the queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One parsed result waiting for the output stage.
   typedef struct packed {
      logic [7:0]  sensor;
      logic [7:0]  msg_type;
      logic [15:0] length;
      logic [15:0] offset;
      logic [7:0]  data;
      logic        empty;
      logic        last;
   } hfr_entry_type;

   // Map a type byte to its message kind.
   function automatic logic [1:0] kind_of(input logic [7:0] t);
      logic [1:0] k;
      unique case (t)
         TYPE_DATA_EVENT:  k = KIND_DATA_EVENT;
         TYPE_SENSOR_INFO: k = KIND_SENSOR_INFO;
         TYPE_FW_VERSION:  k = KIND_FW_VERSION;
         default:          k = KIND_OTHER;
      endcase
      return k;
   endfunction

endpackage

[rtl/core/hfr_front.sv]
module hfr_front
   import hfr_pkg::*;
#(
   parameter int SYNC_COUNT = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [7:0]    csr_wr_data,
   input  logic          accept,
   input  logic [7:0]    rx_byte,
   output logic          push,
   output hfr_entry_type push_entry
);

   typedef enum logic [1:0] {
      MODE_SYNC,
      MODE_HEADER,
      MODE_DATA
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  sensor_ff, sensor_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  sync_char_ff, sync_char_in;
   logic [16:0] pos_inc;

   assign pos_inc = {1'b0, pos_ff} + 17'd1;

   // Parser: sync hunt, header capture and payload tagging for each accepted byte.
   always_comb begin
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      sensor_in    = sensor_ff;
      type_in      = type_ff;
      length_in    = length_ff;
      sync_char_in = csr_wr_en ? csr_wr_data : sync_char_ff;
      push         = 1'b0;
      push_entry.sensor   = sensor_ff;
      push_entry.msg_type = type_ff;
      push_entry.length   = length_ff;
      push_entry.offset   = pos_ff;
      push_entry.data     = rx_byte;
      push_entry.empty    = 1'b0;
      push_entry.last     = 1'b0;
      if (accept) begin
         unique case (mode_ff)
            MODE_HEADER: begin
               if (pos_ff == HDR_IDX_SENSOR) begin
                  sensor_in = rx_byte;
               end
               if (pos_ff == HDR_IDX_TYPE) begin
                  type_in = rx_byte;
               end
               if (pos_ff == HDR_IDX_LEN_HI) begin
                  length_in = {rx_byte, length_ff[7:0]};
               end
               if (pos_ff == HDR_IDX_LEN_LO) begin
                  length_in = {length_ff[15:8], rx_byte};
               end
               if (pos_ff == HDR_IDX_LAST) begin
                  pos_in = 16'd0;
                  if (length_ff == 16'd0) begin
                     // A zero-length message ends here with one empty result.
                     mode_in          = MODE_SYNC;
                     push             = 1'b1;
                     push_entry.offset = 16'd0;
                     push_entry.data   = 8'd0;
                     push_entry.empty  = 1'b1;
                     push_entry.last   = 1'b1;
                  end else begin
                     mode_in = MODE_DATA;
                  end
               end else begin
                  pos_in = pos_inc[15:0];
               end
            end
            MODE_DATA: begin
               push            = 1'b1;
               push_entry.last = (pos_inc >= {1'b0, length_ff});
               if (pos_inc >= {1'b0, length_ff}) begin
                  mode_in = MODE_SYNC;
                  pos_in  = 16'd0;
               end else begin
                  pos_in = pos_inc[15:0];
               end
            end
            default: begin
               // Sync hunt counts consecutive frame start characters.
               mode_in = MODE_SYNC;
               if (rx_byte == sync_char_ff) begin
                  if (pos_inc >= 17'(SYNC_COUNT)) begin
                     mode_in = MODE_HEADER;
                     pos_in  = 16'd0;
                  end else begin
                     pos_in = pos_inc[15:0];
                  end
               end else begin
                  pos_in = 16'd0;
               end
            end
         endcase
      end
   end

   // State and header registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SYNC;
         pos_ff       <= 16'd0;
         sensor_ff    <= 8'd0;
         type_ff      <= 8'd0;
         length_ff    <= 16'd0;
         sync_char_ff <= SYNC_CHAR_RESET;
      end else begin
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         sensor_ff    <= sensor_in;
         type_ff      <= type_in;
         length_ff    <= length_in;
         sync_char_ff <= sync_char_in;
      end
   end

endmodule

[rtl/core/hfr_queue.sv]
module hfr_queue
   import hfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  hfr_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          head_valid,
   output hfr_entry_type head_entry
);

   hfr_entry_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count exceeds depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");
`endif

endmodule

[rtl/core/hfr_back.sv]
module hfr_back
   import hfr_pkg::*;
#(
   parameter int BUFFER_BYTES = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  hfr_entry_type head_entry,
   output logic          pop,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output logic [7:0]    rsp_msg_sensor,
   output logic [7:0]    rsp_msg_type,
   output logic [15:0]   rsp_msg_length,
   output logic [1:0]    rsp_msg_kind,
   output logic [15:0]   rsp_payload_offset,
   output logic [7:0]    rsp_payload_byte,
   output logic          rsp_empty_res,
   output logic          rsp_beyond_buffer,
   output logic          rsp_last
);

   logic        valid_ff, valid_in;
   logic [7:0]  sensor_ff;
   logic [7:0]  type_ff;
   logic [15:0] length_ff;
   logic [1:0]  kind_ff;
   logic [15:0] offset_ff;
   logic [7:0]  data_ff;
   logic        empty_ff;
   logic        beyond_ff;
   logic        last_ff;

   // Load the output register whenever it is free or being drained.
   assign pop      = head_valid && (!valid_ff || !rsp_stall);
   assign valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload: classify the type and check the offset against the buffer.
   always_ff @(posedge clock) begin
      if (pop) begin
         sensor_ff <= head_entry.sensor;
         type_ff   <= head_entry.msg_type;
         length_ff <= head_entry.length;
         kind_ff   <= kind_of(head_entry.msg_type);
         offset_ff <= head_entry.offset;
         data_ff   <= head_entry.data;
         empty_ff  <= head_entry.empty;
         beyond_ff <= ({1'b0, head_entry.offset} >= 17'(BUFFER_BYTES));
         last_ff   <= head_entry.last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_msg_sensor     = sensor_ff;
   assign rsp_msg_type       = type_ff;
   assign rsp_msg_length     = length_ff;
   assign rsp_msg_kind       = kind_ff;
   assign rsp_payload_offset = offset_ff;
   assign rsp_payload_byte   = data_ff;
   assign rsp_empty_res      = empty_ff;
   assign rsp_beyond_buffer  = beyond_ff;
   assign rsp_last           = last_ff;

`ifndef SYNTH
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && empty_ff) |-> (last_ff && !beyond_ff && offset_ff == 16'd0))
      else $error("empty result must be a final result at offset zero");
`endif

endmodule

[rtl/core/hub_frame_receiver_core.sv]
// Frame receiver: one byte transfer per clock on the request side when results drain.
// Path: a byte transfer that causes a result writes a queue slot, and the output register
// loads from the queue head before rsp_valid rises.
// Throughput: one byte per cycle while results drain; the output register reloads while it
// drains, and the two-entry queue between parser and output absorbs result stalls.
// Reset (synchronous, active high): sync hunt, sync character 0x7E, header fields zero,
// queue and output register empty.
module hub_frame_receiver_core
   import hfr_pkg::*;
#(
   parameter int SYNC_COUNT   = 4,
   parameter int BUFFER_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_msg_sensor,
   output logic [7:0]  rsp_msg_type,
   output logic [15:0] rsp_msg_length,
   output logic [1:0]  rsp_msg_kind,
   output logic [15:0] rsp_payload_offset,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_empty_res,
   output logic        rsp_beyond_buffer,
   output logic        rsp_last
);

   logic          accept;
   logic          push;
   hfr_entry_type push_entry;
   logic          pop;
   logic          full;
   logic          head_valid;
   hfr_entry_type head_entry;

   // The parser stalls only when the queue has no room.
   assign req_stall = full;
   assign accept    = req_valid && !full;

   hfr_front #(
      .SYNC_COUNT (SYNC_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .push        (push),
      .push_entry  (push_entry)
   );

   hfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   hfr_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_msg_sensor     (rsp_msg_sensor),
      .rsp_msg_type       (rsp_msg_type),
      .rsp_msg_length     (rsp_msg_length),
      .rsp_msg_kind       (rsp_msg_kind),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_empty_res      (rsp_empty_res),
      .rsp_beyond_buffer  (rsp_beyond_buffer),
      .rsp_last           (rsp_last)
   );

endmodule
